/* rtl/core/lphm_pkg.sv */
// Shared types and constants for the linear probing hash map.
// No dependencies; used by lphm_entry_ram, lphm_probe_ctrl and linear_probe_hash_map.
package lphm_pkg;

  // Table geometry. SLOTS is a power of two, so the home slot is a mask of the key.
  localparam int unsigned SLOTS      = 64;
  localparam int unsigned SLOT_BITS  = $clog2(SLOTS);
  localparam int unsigned CNT_BITS   = SLOT_BITS + 1;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;

  // Request codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } lphm_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_RESP
  } lphm_state_e;

  // One stored entry: key and value side by side in one memory word
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } lphm_entry_t;

  // Memory access from the controller: one write and one read port
  typedef struct packed {
    logic                 we;
    logic [SLOT_BITS-1:0] waddr;
    lphm_entry_t          wdata;
    logic                 re;
    logic [SLOT_BITS-1:0] raddr;
  } lphm_ram_req_t;

  // One result word
  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] read_value;
    logic                  table_full;
  } lphm_res_t;

endpackage

/* rtl/core/lphm_entry_ram.sv */
// Key/value entry store: one write port, one read port, registered read data.
// Depends on lphm_pkg for the entry and request types.
module lphm_entry_ram (
  input  logic                   clk_i,
  input  lphm_pkg::lphm_ram_req_t req_i,
  output lphm_pkg::lphm_entry_t   rd_data_o
);

  lphm_pkg::lphm_entry_t mem [lphm_pkg::SLOTS];
  lphm_pkg::lphm_entry_t rd_data_q;

  // Write the entry chosen by an insert
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read one slot a cycle during a probe
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/lphm_probe_ctrl.sv */
// Probe sequencer: walks the chain, keeps occupied/used-ever marks and the entry count.
// Depends on lphm_pkg; drives the request port of lphm_entry_ram.
module lphm_probe_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [lphm_pkg::KEY_BITS-1:0]   req_key_i,
  input  logic [lphm_pkg::VALUE_BITS-1:0] req_value_i,
  output lphm_pkg::lphm_ram_req_t       ram_req_o,
  input  lphm_pkg::lphm_entry_t         ram_rd_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output lphm_pkg::lphm_res_t           res_o
);

  localparam int unsigned SB = lphm_pkg::SLOT_BITS;
  localparam int unsigned CB = lphm_pkg::CNT_BITS;
  localparam logic [CB-1:0] SLOTS_C = CB'(lphm_pkg::SLOTS);
  localparam logic [SB-1:0] LAST_SLOT = SB'(lphm_pkg::SLOTS - 1);

  lphm_pkg::lphm_state_e state_q, state_d;
  logic [lphm_pkg::SLOTS-1:0] occ_q, occ_d;
  logic [lphm_pkg::SLOTS-1:0] used_q, used_d;
  logic [CB-1:0] count_q, count_d;
  logic [SB-1:0] slot_q, slot_d;
  logic [CB-1:0] probes_q, probes_d;
  logic          pend_q, pend_d;
  logic [SB-1:0] pend_slot_q, pend_slot_d;
  lphm_pkg::lphm_res_t res_q, res_d;

  logic [1:0]                      type_q;
  logic [lphm_pkg::KEY_BITS-1:0]   key_q;
  logic [lphm_pkg::VALUE_BITS-1:0] value_q;

  logic          req_fire;
  logic          pend_hit;
  logic [SB-1:0] slot_next;

  assign req_fire  = req_valid_i && req_ready_o;
  assign pend_hit  = pend_q && (ram_rd_i.key == key_q);
  assign slot_next = (slot_q == LAST_SLOT) ? '0 : slot_q + SB'(1);

  // Capture the request word
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      type_q  <= req_type_i;
      key_q   <= req_key_i;
      value_q <= req_value_i;
    end
  end

  // Control and mark registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lphm_pkg::ST_IDLE;
      occ_q       <= '0;
      used_q      <= '0;
      count_q     <= '0;
      slot_q      <= '0;
      probes_q    <= '0;
      pend_q      <= 1'b0;
      pend_slot_q <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      used_q      <= used_d;
      count_q     <= count_d;
      slot_q      <= slot_d;
      probes_q    <= probes_d;
      pend_q      <= pend_d;
      pend_slot_q <= pend_slot_d;
      res_q       <= res_d;
    end
  end

  // Next state, probe stepping and memory access
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    used_d      = used_q;
    count_d     = count_q;
    slot_d      = slot_q;
    probes_d    = probes_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    res_d       = res_q;
    ram_req_o   = '0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      lphm_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          // home slot: key modulo SLOTS
          slot_d   = req_key_i[SB-1:0];
          probes_d = '0;
          pend_d   = 1'b0;
          state_d  = lphm_pkg::ST_PROBE;
        end
      end

      lphm_pkg::ST_PROBE: begin
        case (type_q) inside
          lphm_pkg::OP_INSERT: begin
            if (count_q >= SLOTS_C) begin
              res_d   = '{found: 1'b0, read_value: '0, table_full: 1'b1};
              state_d = lphm_pkg::ST_RESP;
            end else if (!occ_q[slot_q]) begin
              // claim the first free slot on the chain
              ram_req_o.we          = 1'b1;
              ram_req_o.waddr       = slot_q;
              ram_req_o.wdata.key   = key_q;
              ram_req_o.wdata.value = value_q;
              occ_d[slot_q]         = 1'b1;
              used_d[slot_q]        = 1'b1;
              count_d               = count_q + CB'(1);
              res_d                 = '0;
              state_d               = lphm_pkg::ST_RESP;
            end else begin
              slot_d = slot_next;
            end
          end

          lphm_pkg::OP_REMOVE, lphm_pkg::OP_LOOKUP: begin
            if (pend_hit) begin
              // the earlier slot on the chain matched
              pend_d = 1'b0;
              if (type_q == lphm_pkg::OP_REMOVE) begin
                occ_d[pend_slot_q] = 1'b0;
                if (count_q != '0) begin
                  count_d = count_q - CB'(1);
                end
                res_d = '{found: 1'b1, read_value: '0, table_full: 1'b0};
              end else begin
                res_d = '{found: 1'b1, read_value: ram_rd_i.value, table_full: 1'b0};
              end
              state_d = lphm_pkg::ST_RESP;
            end else if ((probes_q == SLOTS_C) || !used_q[slot_q]) begin
              // end of chain or every slot seen: miss
              pend_d  = 1'b0;
              res_d   = '0;
              state_d = lphm_pkg::ST_RESP;
            end else begin
              // fetch occupied slots only; freed holes are stepped over
              ram_req_o.re    = occ_q[slot_q];
              ram_req_o.raddr = slot_q;
              pend_d          = occ_q[slot_q];
              pend_slot_d     = slot_q;
              slot_d          = slot_next;
              probes_d        = probes_q + CB'(1);
            end
          end

          default: begin
            // unused request code: no state change, all-zero result
            res_d   = '0;
            state_d = lphm_pkg::ST_RESP;
          end
        endcase
      end

      lphm_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = lphm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lphm_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  // Entry count never exceeds the table size
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLOTS_C)
    else $error("entry count above table size");

  // The count matches the number of occupied marks
  a_count_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CB'($countones(occ_q)))
    else $error("entry count out of step with occupied marks");

  // A pending compare always refers to an occupied slot
  a_pend_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> occ_q[pend_slot_q])
    else $error("pending compare on a free slot");

  // An insert never overwrites an occupied slot
  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> !occ_q[ram_req_o.waddr])
    else $error("insert into occupied slot");

  // An accepted request starts probing in the next cycle
  a_accept_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (state_q == lphm_pkg::ST_PROBE))
    else $error("accepted request did not start probing");

endmodule

/* rtl/core/linear_probe_hash_map.sv */
// Linear probing hash map, 64 slots: one request at a time, one result per request.
// A full chain walk visits every slot; the probe loop steps one slot a cycle.
// The controller passes through its idle state before it takes the next request word;
// the output register lets it do so while a result waits.
// Reset clears occupied/used-ever marks and the count at once; the entry memory stays as is.
module linear_probe_hash_map (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  logic [1:0]                      req_type_i,
  input  logic [lphm_pkg::KEY_BITS-1:0]   req_key_i,
  input  logic [lphm_pkg::VALUE_BITS-1:0] req_value_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic                            found_o,
  output logic [lphm_pkg::VALUE_BITS-1:0] read_value_o,
  output logic                            table_full_o
);

  lphm_pkg::lphm_ram_req_t ram_req;
  lphm_pkg::lphm_entry_t   ram_rd;
  lphm_pkg::lphm_res_t     res;
  lphm_pkg::lphm_res_t     out_q;
  logic                    res_valid;
  logic                    res_ready;
  logic                    out_valid_q;

  lphm_entry_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd)
  );

  lphm_probe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_type_i  (req_type_i),
    .req_key_i   (req_key_i),
    .req_value_i (req_value_i),
    .ram_req_o   (ram_req),
    .ram_rd_i    (ram_rd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: take a new word when empty or being drained
  assign res_ready = !out_valid_q || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign found_o      = out_q.found;
  assign read_value_o = out_q.read_value;
  assign table_full_o = out_q.table_full;

endmodule
